// ----- src/utf8dcw_pkg.sv -----
// Shared types, constants and the display-width function for the UTF-8 decoder.
// No dependencies; every other file in src imports this package.
package utf8dcw_pkg;

  localparam int CpW  = 21;
  localparam int LenW = 3;

  localparam logic [CpW-1:0] REPL_CP  = 21'h00FFFD;
  localparam logic [CpW-1:0] CP_MAX   = 21'h10FFFF;
  localparam logic [CpW-1:0] SURR_LO  = 21'h00D800;
  localparam logic [CpW-1:0] SURR_HI  = 21'h00DFFF;
  localparam logic [CpW-1:0] MIN_CP2  = 21'h000080;
  localparam logic [CpW-1:0] MIN_CP3  = 21'h000800;
  localparam logic [CpW-1:0] MIN_CP4  = 21'h010000;

  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] LEAD2_LO  = 8'hC2;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD3_HI  = 8'hEF;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] LEAD4_HI  = 8'hF4;

  localparam logic [LenW-1:0] LEN1 = 3'd1;
  localparam logic [LenW-1:0] LEN2 = 3'd2;
  localparam logic [LenW-1:0] LEN3 = 3'd3;
  localparam logic [LenW-1:0] LEN4 = 3'd4;

  // Pending multi-byte sequence.
  typedef struct packed {
    logic [CpW-1:0]  partial;
    logic [LenW-1:0] exp_len;
    logic [LenW-1:0] seen;
  } dec_state_t;

  // Results caused by one byte: rep_cnt replacements, then an optional tail.
  typedef struct packed {
    logic [LenW-1:0] rep_cnt;
    logic            tail_valid;
    logic [CpW-1:0]  tail_cp;
    logic [LenW-1:0] tail_len;
    logic            tail_repl;
    logic            tail_width;
  } grp_t;

  // Zero columns for controls and the combining-mark blocks.
  function automatic logic cp_width(input logic [CpW-1:0] cp);
    logic zero;
    zero = (cp < 21'h20) || (cp >= 21'h7F && cp < 21'hA0) ||
           (cp >= 21'h0300 && cp <= 21'h036F) ||
           (cp >= 21'h1AB0 && cp <= 21'h1AFF) ||
           (cp >= 21'h1DC0 && cp <= 21'h1DFF) ||
           (cp >= 21'h20D0 && cp <= 21'h20FF) ||
           (cp >= 21'hFE20 && cp <= 21'hFE2F);
    return !zero;
  endfunction

endpackage

// ----- src/utf8dcw_decode.sv -----
// Combinational byte decoder: pending-sequence update and result group.
// Depends on utf8dcw_pkg.
module utf8dcw_decode (
  input  utf8dcw_pkg::dec_state_t st,
  input  logic [7:0]              data_byte,
  input  logic                    end_of_text,
  output utf8dcw_pkg::dec_state_t st_next,
  output utf8dcw_pkg::grp_t       grp
);
  import utf8dcw_pkg::*;

  logic            pending;
  logic            cont;
  logic            fresh;
  logic [CpW-1:0]  new_partial;
  logic [LenW-1:0] seen_inc;
  logic            val_ok;
  logic [LenW-1:0] lead_len;
  logic [CpW-1:0]  lead_init;

  assign pending     = (st.exp_len >= LEN2) && (st.exp_len <= LEN4) &&
                       (st.seen >= LEN1) && (st.seen < st.exp_len);
  assign cont        = (data_byte[7:6] == 2'b10);
  assign new_partial = {st.partial[CpW-7:0], data_byte[5:0]};
  assign seen_inc    = st.seen + LEN1;

  always_comb begin
    val_ok = 1'b1;
    if (st.exp_len == LEN2 && new_partial < MIN_CP2) val_ok = 1'b0;
    if (st.exp_len == LEN3 && new_partial < MIN_CP3) val_ok = 1'b0;
    if (st.exp_len == LEN4 && new_partial < MIN_CP4) val_ok = 1'b0;
    if (new_partial > CP_MAX) val_ok = 1'b0;
    if (new_partial >= SURR_LO && new_partial <= SURR_HI) val_ok = 1'b0;
  end

  always_comb begin
    lead_len  = '0;
    lead_init = '0;
    if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
      lead_len  = LEN2;
      lead_init = {16'd0, data_byte[4:0]};
    end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
      lead_len  = LEN3;
      lead_init = {17'd0, data_byte[3:0]};
    end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
      lead_len  = LEN4;
      lead_init = {18'd0, data_byte[2:0]};
    end
  end

  always_comb begin
    st_next = '0;
    grp     = '0;
    fresh   = 1'b1;
    if (pending) begin
      if (cont) begin
        fresh = 1'b0;
        if (seen_inc == st.exp_len) begin
          if (val_ok) begin
            grp.tail_valid = 1'b1;
            grp.tail_cp    = new_partial;
            grp.tail_len   = st.exp_len;
          end else begin
            grp.rep_cnt = st.exp_len;
          end
        end else if (end_of_text) begin
          grp.rep_cnt = seen_inc;
        end else begin
          st_next.partial = new_partial;
          st_next.exp_len = st.exp_len;
          st_next.seen    = seen_inc;
        end
      end else begin
        // The pending bytes are each replaced; this byte starts over.
        grp.rep_cnt = st.seen;
      end
    end

    if (fresh) begin
      if (data_byte <= ASCII_MAX) begin
        grp.tail_valid = 1'b1;
        grp.tail_cp    = {13'd0, data_byte};
        grp.tail_len   = LEN1;
      end else if (lead_len == '0 || end_of_text) begin
        grp.tail_valid = 1'b1;
        grp.tail_cp    = REPL_CP;
        grp.tail_len   = LEN1;
        grp.tail_repl  = 1'b1;
      end else begin
        st_next.partial = lead_init;
        st_next.exp_len = lead_len;
        st_next.seen    = LEN1;
      end
    end

    grp.tail_width = cp_width(grp.tail_cp);
  end

endmodule

// ----- src/utf8_decode_column_width_core.sv -----
// Streaming UTF-8 decoder with per-byte replacement and display width.
// Latency: the first result of a byte is shown the cycle after the byte's transaction.
// Throughput: one byte per cycle while each byte causes at most one result and the
// receiver takes every result; a byte causing more results (up to four) holds the
// input side while the single result register drains one result per cycle while m_tready is high.
// Reset (rst, synchronous, active high) drops any pending sequence and queued results.
module utf8_decode_column_width_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [20:0] code_point, [23:21] seq_length, [24] width
  output logic        m_tuser,   // replaced
  output logic        m_tlast    // last
);
  import utf8dcw_pkg::*;

  // Pending sequence state, updated on every input transaction.
  dec_state_t st;
  dec_state_t st_next;

  // Result register: the whole group of results one byte produced. Replacements for
  // pending bytes go out first, then the optional tail result.
  grp_t grp;
  grp_t grp_next;

  logic s_acc;
  logic m_acc;
  logic grp_busy;
  logic grp_has;
  logic on_rep;

  utf8dcw_decode u_decode (
    .st          (st),
    .data_byte   (s_tdata),
    .end_of_text (s_tlast),
    .st_next     (st_next),
    .grp         (grp_next)
  );

  assign grp_busy = (grp.rep_cnt != '0) || grp.tail_valid;
  assign grp_has  = (grp_next.rep_cnt != '0) || grp_next.tail_valid;
  assign on_rep   = (grp.rep_cnt != '0);

  // A new byte is taken when the result register is empty or its final result is
  // leaving in this cycle, so a steady stream of single-result bytes runs at full rate.
  assign s_tready = !grp_busy || (m_acc && m_tlast);
  assign s_acc    = s_tvalid && s_tready;
  assign m_acc    = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= '0;
      grp <= '0;
    end else begin
      if (s_acc) begin
        st <= st_next;
      end
      if (s_acc && grp_has) begin
        grp <= grp_next;
      end else if (m_acc) begin
        if (on_rep) begin
          grp.rep_cnt <= grp.rep_cnt - LEN1;
        end else begin
          grp.tail_valid <= 1'b0;
        end
      end
    end
  end

  // Output view of the head of the group.
  assign m_tvalid = grp_busy;
  always_comb begin
    if (on_rep) begin
      m_tdata = {7'd0, 1'b1, LEN1, REPL_CP};
      m_tuser = 1'b1;
      m_tlast = (grp.rep_cnt == LEN1) && !grp.tail_valid;
    end else begin
      m_tdata = {7'd0, grp.tail_width, grp.tail_len, grp.tail_cp};
      m_tuser = grp.tail_repl;
      m_tlast = 1'b1;
    end
  end

endmodule

// ----- src/utf8dcw_checker.sv -----
// Port-level checker for the UTF-8 decoder core, attached by the bind below.
// Depends on utf8dcw_pkg and utf8_decode_column_width_core.
module utf8dcw_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);
  import utf8dcw_pkg::*;

  // A result held back keeps its data and its last flag.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[20:0] <= CP_MAX && m_tdata[23:21] >= LEN1 &&
                 m_tdata[23:21] <= LEN4)
    else $error("code point or length out of range");

  a_repl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[20:0] == REPL_CP && m_tdata[23:21] == LEN1 &&
                            m_tdata[24])
    else $error("malformed replacement result");

  // An ASCII byte always causes at least one result, so one taken while the
  // output is idle shows a result in the next cycle.
  a_ascii: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid && !s_tdata[7] |=> m_tvalid)
    else $error("byte with results lost");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result visible after reset");

endmodule

bind utf8_decode_column_width_core utf8dcw_checker u_utf8dcw_checker (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for the streaming UTF-8 decoder with display width.
// Depends on src/utf8dcw_pkg.sv and src/utf8_decode_column_width_core.sv.
`timescale 1ns / 100ps

module testbench;
  import utf8dcw_pkg::*;

  // One decoded result as it leaves the block.
  typedef struct packed {
    logic [CpW-1:0]  cp;
    logic [LenW-1:0] len;
    logic            repl;
    logic            cols;
    logic            last;
  } glyph_t;

  // One text byte to send. When pinned is set, the expected single result is
  // written out by hand in want and takes the place of the predicted one.
  typedef struct packed {
    logic   pinned;
    logic   [7:0] b;
    logic   eot;
    glyph_t want;
  } text_byte_t;

  // Kinds of random text fragments.
  typedef enum int {
    FRAG_ASCII, FRAG_TWO, FRAG_THREE, FRAG_FOUR,
    FRAG_NOISE, FRAG_CUT, FRAG_BAD, FRAG_STRAY
  } frag_kind_t;

  localparam int RandomBytes = 480;
  localparam int HoldAt      = 140;  // receiver starts its long hold-off here
  localparam int DrainAt     = 270;  // sender waits for every result here
  localparam int CalmFrom    = 330;  // no idling on either side in this window
  localparam int CalmTo      = 450;
  localparam int HoldCycles  = 240;

  // The opening directed text. Rows with a typed result are the ones that can
  // be read off at a glance; the others go through the predictor.
  localparam text_byte_t OPENING [25] = '{
    // NUL and DEL are controls with zero columns; 'A' is one column wide.
    '{1'b1, 8'h00, 1'b0, '{21'h000000, LEN1, 1'b0, 1'b0, 1'b1}},
    '{1'b1, 8'h7F, 1'b0, '{21'h00007F, LEN1, 1'b0, 1'b0, 1'b1}},
    '{1'b1, 8'h41, 1'b0, '{21'h000041, LEN1, 1'b0, 1'b1, 1'b1}},
    // Bytes that can never start a sequence are each replaced.
    '{1'b1, 8'h80, 1'b0, '{REPL_CP, LEN1, 1'b1, 1'b1, 1'b1}},
    '{1'b1, 8'hC1, 1'b0, '{REPL_CP, LEN1, 1'b1, 1'b1, 1'b1}},
    '{1'b1, 8'hFF, 1'b1, '{REPL_CP, LEN1, 1'b1, 1'b1, 1'b1}},
    // U+0300, the first combining mark.
    '{1'b0, 8'hCC, 1'b0, '0},
    '{1'b0, 8'h80, 1'b0, '0},
    // U+10FFFF, the largest scalar value.
    '{1'b0, 8'hF4, 1'b0, '0},
    '{1'b0, 8'h8F, 1'b0, '0},
    '{1'b0, 8'hBF, 1'b0, '0},
    '{1'b0, 8'hBF, 1'b0, '0},
    // A surrogate is rejected on its final byte: three replacements.
    '{1'b0, 8'hED, 1'b0, '0},
    '{1'b0, 8'hA0, 1'b0, '0},
    '{1'b0, 8'h80, 1'b0, '0},
    // Overlong three-byte NUL: three replacements.
    '{1'b0, 8'hE0, 1'b0, '0},
    '{1'b0, 8'h80, 1'b0, '0},
    '{1'b0, 8'h80, 1'b0, '0},
    // A sequence broken by ASCII: two replacements, then 'A' itself.
    '{1'b0, 8'hE2, 1'b0, '0},
    '{1'b0, 8'h82, 1'b0, '0},
    '{1'b0, 8'h41, 1'b0, '0},
    // Lone lead byte at the end of the text.
    '{1'b1, 8'hF0, 1'b1, '{REPL_CP, LEN1, 1'b1, 1'b1, 1'b1}},
    // Text that stops inside a four-byte sequence: two replacements.
    '{1'b0, 8'hF0, 1'b0, '0},
    '{1'b0, 8'h9F, 1'b1, '0},
    // The lead byte of U+20AC after the truncated text, to show the state was cleared.
    '{1'b0, 8'hE2, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  always #4 clk = ~clk;

  utf8_decode_column_width_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  text_byte_t text [$];        // every byte the sender will offer, in order
  glyph_t     glyphs_due [$];  // predicted results not yet seen
  glyph_t     decoded [$];     // results of the byte being predicted

  // Predictor copy of the pending multi-byte sequence.
  logic [CpW-1:0]  seq_value = '0;
  logic [LenW-1:0] seq_need = '0;
  logic [LenW-1:0] seq_have = '0;

  int  errors = 0;
  int  bytes_taken = 0;
  int  glyphs_seen = 0;
  int  repl_seen = 0;
  int  narrow_seen = 0;
  bit  calm = 1'b0;
  bit  hold_asked = 1'b0;
  bit  hold_done = 1'b0;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Display columns: zero for C0/C1 controls and the combining-mark blocks.
  function automatic logic columns_of(input logic [CpW-1:0] cp);
    if (cp < 21'h20 || (cp >= 21'h7F && cp < 21'hA0)) return 1'b0;
    if ((cp >= 21'h0300 && cp <= 21'h036F) || (cp >= 21'h1AB0 && cp <= 21'h1AFF) ||
        (cp >= 21'h1DC0 && cp <= 21'h1DFF) || (cp >= 21'h20D0 && cp <= 21'h20FF) ||
        (cp >= 21'hFE20 && cp <= 21'hFE2F)) return 1'b0;
    return 1'b1;
  endfunction

  // A finished sequence must be minimal, outside the surrogates and in range.
  function automatic logic value_legal(input logic [CpW-1:0] v, input logic [LenW-1:0] n);
    if (n == LEN2 && v < MIN_CP2) return 1'b0;
    if (n == LEN3 && v < MIN_CP3) return 1'b0;
    if (n == LEN4 && v < MIN_CP4) return 1'b0;
    if (v > CP_MAX) return 1'b0;
    if (v >= SURR_LO && v <= SURR_HI) return 1'b0;
    return 1'b1;
  endfunction

  task automatic add_glyph(input logic [CpW-1:0] cp, input logic [LenW-1:0] n,
                           input logic repl);
    glyph_t g;
    g.cp   = cp;
    g.len  = n;
    g.repl = repl;
    g.cols = columns_of(cp);
    g.last = 1'b0;
    if (decoded.size() < 4) decoded.push_back(g);
  endtask

  task automatic add_replacements(input logic [LenW-1:0] n);
    int i;
    for (i = 0; i < n; i++) add_glyph(REPL_CP, LEN1, 1'b1);
  endtask

  task automatic drop_sequence();
    seq_value = '0;
    seq_need  = '0;
    seq_have  = '0;
  endtask

  // Works out the results of one byte into decoded and advances the state.
  task automatic decode_byte(input logic [7:0] b, input logic eot);
    logic            fresh;
    logic [LenW-1:0] need;
    logic [CpW-1:0]  lead_bits;
    fresh     = 1'b1;
    need      = '0;
    lead_bits = '0;
    decoded.delete();
    if (seq_need >= LEN2 && seq_need <= LEN4 && seq_have >= LEN1 && seq_have < seq_need) begin
      if (b[7:6] == 2'b10) begin
        fresh     = 1'b0;
        seq_value = {seq_value[CpW-7:0], b[5:0]};
        seq_have  = seq_have + 1'b1;
        if (seq_have == seq_need) begin
          if (value_legal(seq_value, seq_need)) add_glyph(seq_value, seq_need, 1'b0);
          else add_replacements(seq_need);
          drop_sequence();
        end else if (eot) begin
          add_replacements(seq_have);
          drop_sequence();
        end
      end else begin
        // The pending bytes are lost; this byte then starts over.
        add_replacements(seq_have);
        drop_sequence();
      end
    end else begin
      drop_sequence();
    end

    if (fresh) begin
      if (b <= ASCII_MAX) begin
        add_glyph({13'b0, b}, LEN1, 1'b0);
      end else begin
        if (b >= LEAD2_LO && b <= LEAD2_HI) begin
          need = LEN2;
          lead_bits = {16'b0, b[4:0]};
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
          need = LEN3;
          lead_bits = {17'b0, b[3:0]};
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
          need = LEN4;
          lead_bits = {18'b0, b[2:0]};
        end
        if (need == '0 || eot) begin
          add_glyph(REPL_CP, LEN1, 1'b1);
        end else begin
          seq_value = lead_bits;
          seq_need  = need;
          seq_have  = LEN1;
        end
      end
    end

    if (eot) drop_sequence();
    if (decoded.size() > 0) decoded[decoded.size()-1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------

  task automatic add_byte(input logic [7:0] b, input logic eot);
    text_byte_t t;
    t        = '0;
    t.b      = b;
    t.eot    = eot;
    text.push_back(t);
  endtask

  // Appends the first keep bytes of the n-byte encoding of cp. The encoding
  // is built from the bits alone, so overlong and out-of-range forms work too.
  task automatic add_seq(input logic [CpW-1:0] cp, input int n, input int keep,
                         input logic eot_end);
    logic [7:0] enc [4];
    int i;
    enc[0] = 8'h00;
    enc[1] = 8'h80;
    enc[2] = 8'h80;
    enc[3] = 8'h80;
    case (n)
      1: enc[0] = {1'b0, cp[6:0]};
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (i = 0; i < keep; i++) add_byte(enc[i], eot_end && (i == keep - 1));
  endtask

  // A legal scalar value that needs exactly n bytes; for two or three bytes sometimes a combining mark.
  function automatic logic [CpW-1:0] legal_value(input int n);
    logic [CpW-1:0] v;
    case (n)
      1: v = CpW'($urandom_range(21'h7F, 0));
      2: v = ($urandom_range(3) == 0) ? CpW'($urandom_range(21'h36F, 21'h300))
                                       : CpW'($urandom_range(21'h7FF, 21'h80));
      3: begin
        if ($urandom_range(3) == 0) begin
          case ($urandom_range(3))
            0: v = CpW'($urandom_range(21'h1AFF, 21'h1AB0));
            1: v = CpW'($urandom_range(21'h1DFF, 21'h1DC0));
            2: v = CpW'($urandom_range(21'h20FF, 21'h20D0));
            default: v = CpW'($urandom_range(21'hFE2F, 21'hFE20));
          endcase
        end else begin
          v = CpW'($urandom_range(21'hFFFF, 21'h800));
          if (v >= SURR_LO && v <= SURR_HI) v = v ^ 21'h2000;
        end
      end
      default: v = CpW'($urandom_range(CP_MAX, MIN_CP4));
    endcase
    return v;
  endfunction

  task automatic build_text();
    frag_kind_t kind;
    int r;
    int n;
    int keep;
    logic eot;
    foreach (OPENING[i]) text.push_back(OPENING[i]);
    while (text.size() < $size(OPENING) + RandomBytes) begin
      r = $urandom_range(99);
      kind = (r < 28) ? FRAG_ASCII : (r < 46) ? FRAG_TWO : (r < 62) ? FRAG_THREE :
             (r < 74) ? FRAG_FOUR : (r < 82) ? FRAG_NOISE : (r < 89) ? FRAG_CUT :
             (r < 95) ? FRAG_BAD : FRAG_STRAY;
      eot = ($urandom_range(15) == 0);
      case (kind)
        FRAG_ASCII: add_seq(legal_value(1), 1, 1, eot);
        FRAG_TWO:   add_seq(legal_value(2), 2, 2, eot);
        FRAG_THREE: add_seq(legal_value(3), 3, 3, eot);
        FRAG_FOUR:  add_seq(legal_value(4), 4, 4, eot);
        FRAG_NOISE: add_byte(8'($urandom_range(255)), eot);
        FRAG_STRAY: add_byte(8'($urandom_range(8'hBF, 8'h80)), eot);
        FRAG_CUT: begin
          // Either the text ends inside the sequence, or a byte that is not
          // a continuation breaks it.
          n = $urandom_range(4, 2);
          keep = $urandom_range(n - 1, 1);
          add_seq(legal_value(n), n, keep, eot);
          if (!eot) begin
            if ($urandom_range(1) == 0) add_byte(8'($urandom_range(8'h7F, 8'h00)), 1'b0);
            else add_byte(8'($urandom_range(8'hFF, 8'hC0)), 1'b0);
          end
        end
        default: begin
          case ($urandom_range(2))
            0: begin
              n = $urandom_range(4, 2);
              add_seq(CpW'($urandom_range((n == 2) ? 21'h7F : (n == 3) ? 21'h7FF : 21'hFFFF,
                                          0)),
                      n, n, eot);
            end
            1: add_seq(CpW'($urandom_range(SURR_HI, SURR_LO)), 3, 3, eot);
            default: add_seq(CpW'($urandom_range(21'h1FFFFF, 21'h110000)), 4, 4, eot);
          endcase
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)", what, got, want,
             glyphs_seen);
  endtask

  // Output transactions are checked before the byte accepted at the same edge
  // is predicted; that byte's results cannot appear before the next cycle.
  always @(posedge clk) begin : scoreboard
    glyph_t w;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (glyphs_due.size() == 0) begin
          report_mismatch("unexpected result, code point", int'(m_tdata[20:0]), 0);
        end else begin
          w = glyphs_due.pop_front();
          if (m_tdata[20:0] !== w.cp)
            report_mismatch("code_point", int'(m_tdata[20:0]), int'(w.cp));
          if (m_tdata[23:21] !== w.len)
            report_mismatch("seq_length", int'(m_tdata[23:21]), int'(w.len));
          if (m_tuser !== w.repl)
            report_mismatch("replaced", int'(m_tuser), int'(w.repl));
          if (m_tdata[24] !== w.cols)
            report_mismatch("width", int'(m_tdata[24]), int'(w.cols));
          if (m_tlast !== w.last)
            report_mismatch("last", int'(m_tlast), int'(w.last));
        end
        glyphs_seen++;
        if (m_tuser === 1'b1) repl_seen++;
        if (m_tdata[24] === 1'b0) narrow_seen++;
      end
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata, s_tlast);
        if (text[bytes_taken].pinned) begin
          glyphs_due.push_back(text[bytes_taken].want);
        end else begin
          foreach (decoded[i]) glyphs_due.push_back(decoded[i]);
        end
        bytes_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random back-pressure, one long hold-off on request.
  // ---------------------------------------------------------------------

  initial begin : result_sink
    int k;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_asked && !hold_done) begin
        // Hold off long enough that the result register fills and the
        // decoder has to stall the byte stream.
        m_tready <= 1'b0;
        for (k = 0; k < HoldCycles; k++) @(posedge clk);
        hold_done = 1'b1;
      end
      m_tready <= calm || ($urandom_range(99) >= 19);
    end
  end

  // ---------------------------------------------------------------------
  // Sender, reset and the end of the run.
  // ---------------------------------------------------------------------

  initial begin : byte_source
    int  idx;
    int  waited;
    bit  idle;
    build_text();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (idx = 0; idx < text.size(); idx++) begin
      calm = (idx >= CalmFrom && idx < CalmTo);
      if (idx == HoldAt) hold_asked = 1'b1;
      idle = (idx == DrainAt) || (!calm && $urandom_range(99) < 19);
      if (idle) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (!calm && $urandom_range(99) < 19);
        // Once in the run the sender pauses until every result is out.
        if (idx == DrainAt) while (glyphs_due.size() != 0) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= text[idx].b;
      s_tlast  <= text[idx].eot;
      do @(posedge clk); while (!s_tready);
    end
    s_tvalid <= 1'b0;
    calm = 1'b0;

    waited = 0;
    while (glyphs_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (glyphs_due.size() != 0)
      report_mismatch("results never delivered, count", 0, glyphs_due.size());
    // The run then goes on to catch any stray result after the last expected one.
    repeat (20) @(posedge clk);

    $display("Sent %0d text bytes (%0d directed) and checked %0d decoded results,",
             bytes_taken, $size(OPENING), glyphs_seen);
    $display("including %0d replacements and %0d zero-width code points.",
             repl_seen, narrow_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches found", errors);
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout after %0d bytes and %0d results", bytes_taken, glyphs_seen);
    $display("Verification failed");
    $finish;
  end

endmodule
